// ===== hw/rtl/challenge_handshake_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Challenge handshake table assertion macros
// Shared wrappers for the concurrent checks of the challenge handshake table.
// ----------------------------------------------------------------------------
`ifndef CHALLENGE_HANDSHAKE_TABLE_UNIT_ASSERT_SVH
`define CHALLENGE_HANDSHAKE_TABLE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CHTAB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define CHTAB_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/chtab_pkg.sv =====
// ----------------------------------------------------------------------------
// Challenge handshake table package
// Payload types, request and reply codes, and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package chtab_pkg;

    // Request kinds carried in the func field.
    typedef enum logic [1:0] {
        FUNC_GET_CHALLENGE = 2'd0,
        FUNC_CONNECT       = 2'd1,
        FUNC_TICK          = 2'd2
    } t_func;

    // Reply kinds.
    typedef enum logic [1:0] {
        REPLY_CHALLENGE    = 2'd0,
        REPLY_TABLE_FULL   = 2'd1,
        REPLY_CONNECTED    = 2'd2,
        REPLY_CLIENTS_FULL = 2'd3
    } t_reply_kind;

    // Input transfer payload.
    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] client_addr;
        logic [31:0] challenge_value;
        logic [31:0] random_word;
        logic [31:0] now_ms;
    } t_req;

    // Output transfer payload.
    typedef struct packed {
        t_reply_kind reply_kind;
        logic [47:0] reply_addr;
        logic [19:0] reply_challenge;
        logic [3:0]  client_slot;
    } t_reply;

    // One pending challenge entry.
    typedef struct packed {
        logic [47:0] addr;
        logic [19:0] chal;
        logic [31:0] issue_time;
    } t_pend_entry;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_MOD_WAIT,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_MOVE,
        ST_EMIT
    } t_state;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam logic [20:0] CHAL_MOD      = 21'd1000000;
    // Reciprocal of one million scaled by 2^50 and rounded up; the quotient it
    // gives is exact for every 32-bit word.
    localparam logic [31:0] CHAL_RECIP    = 32'h431B_DE83;
    localparam int          CHAL_SHIFT    = 50;

endpackage

`default_nettype wire

// ===== hw/rtl/challenge_handshake_table_unit.sv =====
// ----------------------------------------------------------------------------
// Challenge handshake table unit
// Server-side pending challenge table and client slot allocator.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (i_in_valid / o_in_stall) and replies
// leave on the output channel (o_out_valid / i_out_stall). One request is
// handled at a time; o_in_stall is high from the transfer until the unit is
// idle again, and the next transfer can come once it is. Each searched
// pending entry is read through the single read port of the memory.
// A new challenge is replied after all stored entries are searched, with the
// remainder computed alongside; a full table replies after the search too.
// A matching connect replies once the search reaches the matching entry.
// Requests with no reply finish at an entry with their address, or when the
// search runs off the end. A timeout tick reads and checks every entry; a
// removed entry is replaced by the last one, which is checked next.
// Replies sit in an output register, so the next request is taken while a
// reply waits; if the receiver stalls and a second reply is ready, the unit
// holds it and stalls its input until the output register frees up. Reset
// empties both tables and sets the timeout to 10000 ms; timeout writes on
// i_cfg_wr_en are taken at any time but are meant for an idle unit.
// ----------------------------------------------------------------------------
`default_nettype none

module challenge_handshake_table_unit
    import chtab_pkg::*;
#(
    parameter int MAX_PENDING = 16,
    parameter int MAX_CLIENTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_req        i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_reply           o_out_data,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    `include "challenge_handshake_table_unit_assert.svh"

    localparam int PW  = $clog2(MAX_PENDING + 1);
    localparam int PIW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CW  = $clog2(MAX_CLIENTS + 1);

    t_state          r_state, n_state;
    t_req            r_req;
    t_reply          r_res, n_res;
    t_reply          r_out_data;
    logic            r_out_valid;
    logic [31:0]     r_timeout;
    logic [PW-1:0]   r_idx, n_idx;
    logic [PW-1:0]   r_pend_count, n_pend_count;
    logic [CW-1:0]   r_cli_count, n_cli_count;

    logic            w_in_accept;
    logic            w_out_free;
    logic            w_idx_end;
    logic            w_pend_full;
    logic            w_cli_full;
    logic            w_addr_hit;
    logic            w_chal_hit;
    logic            w_expired;
    logic            w_is_get;
    logic            w_is_conn;
    logic [PIW-1:0]  w_last_idx;

    logic            mem_rd_en;
    logic [PIW-1:0]  mem_rd_addr;
    t_pend_entry     mem_rd_data;
    logic            mem_wr_en;
    logic [PIW-1:0]  mem_wr_addr;
    t_pend_entry     mem_wr_data;

    logic            mod_start;
    logic            mod_done;
    logic [19:0]     mod_rem;

    chtab_pend_mem #(
        .DEPTH(MAX_PENDING)
    ) u_pend_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    chtab_mod_unit u_mod_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_in_data.random_word),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Handshake and status terms.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_idx_end   = (r_idx >= r_pend_count);
    assign w_pend_full = (r_pend_count >= PW'(MAX_PENDING));
    assign w_cli_full  = (r_cli_count >= CW'(MAX_CLIENTS));
    assign w_addr_hit  = (mem_rd_data.addr == r_req.client_addr);
    assign w_chal_hit  = ({12'd0, mem_rd_data.chal} == r_req.challenge_value);
    assign w_expired   = (32'(r_req.now_ms - mem_rd_data.issue_time) > r_timeout);
    assign w_is_get    = (r_req.func == FUNC_GET_CHALLENGE);
    assign w_is_conn   = (r_req.func == FUNC_CONNECT);
    assign w_last_idx  = PIW'(r_pend_count - 1'b1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    case (i_in_data.func)
                        FUNC_GET_CHALLENGE: n_state = ST_SRCH_RD;
                        FUNC_CONNECT:       n_state = ST_SRCH_RD;
                        FUNC_TICK:          n_state = ST_TICK_RD;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SRCH_RD: begin
                if (!w_idx_end) begin
                    n_state = ST_SRCH_CHK;
                end else if (w_is_get) begin
                    n_state = w_pend_full ? ST_EMIT : ST_MOD_WAIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SRCH_CHK: begin
                if (!w_addr_hit) begin
                    n_state = ST_SRCH_RD;
                end else if (w_is_conn && w_chal_hit) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_TICK_RD: begin
                n_state = w_idx_end ? ST_IDLE : ST_TICK_CHK;
            end
            ST_TICK_CHK: begin
                n_state = w_expired ? ST_TICK_MOVE : ST_TICK_RD;
            end
            ST_TICK_MOVE: begin
                n_state = ST_TICK_RD;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory port, remainder start and table updates.
    always_comb begin
        n_idx        = r_idx;
        n_pend_count = r_pend_count;
        n_cli_count  = r_cli_count;
        n_res        = r_res;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_idx[PIW-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_idx[PIW-1:0];
        mem_wr_data  = mem_rd_data;
        mod_start    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (w_in_accept && (i_in_data.func == FUNC_GET_CHALLENGE)) begin
                    mod_start = 1'b1;
                end
            end
            ST_SRCH_RD: begin
                if (!w_idx_end) begin
                    mem_rd_en = 1'b1;
                end else if (w_is_get && w_pend_full) begin
                    n_res = '{reply_kind: REPLY_TABLE_FULL,
                              reply_addr: r_req.client_addr,
                              reply_challenge: '0, client_slot: '0};
                end
            end
            ST_SRCH_CHK: begin
                if (!w_addr_hit) begin
                    n_idx = r_idx + 1'b1;
                end else if (w_is_conn && w_chal_hit) begin
                    if (w_cli_full) begin
                        n_res = '{reply_kind: REPLY_CLIENTS_FULL,
                                  reply_addr: r_req.client_addr,
                                  reply_challenge: '0, client_slot: '0};
                    end else begin
                        n_res = '{reply_kind: REPLY_CONNECTED,
                                  reply_addr: r_req.client_addr,
                                  reply_challenge: '0,
                                  client_slot: 4'(r_cli_count)};
                        n_cli_count = r_cli_count + 1'b1;
                    end
                end
            end
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    // Append the new entry at the end of the table.
                    mem_wr_en    = 1'b1;
                    mem_wr_addr  = r_pend_count[PIW-1:0];
                    mem_wr_data  = '{addr: r_req.client_addr, chal: mod_rem,
                                     issue_time: r_req.now_ms};
                    n_pend_count = r_pend_count + 1'b1;
                    n_res = '{reply_kind: REPLY_CHALLENGE,
                              reply_addr: r_req.client_addr,
                              reply_challenge: mod_rem, client_slot: '0};
                end
            end
            ST_TICK_RD: begin
                if (!w_idx_end) begin
                    mem_rd_en = 1'b1;
                end
            end
            ST_TICK_CHK: begin
                // An expired entry is replaced by the last one, which is checked next.
                if (w_expired) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = w_last_idx;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TICK_MOVE: begin
                mem_wr_en    = 1'b1;
                n_pend_count = r_pend_count - 1'b1;
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_pend_count <= '0;
            r_cli_count  <= '0;
            r_timeout    <= TIMEOUT_RESET;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_count <= n_pend_count;
            r_cli_count  <= n_cli_count;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

    // Request capture and pending reply.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req <= i_in_data;
        end
        r_res <= n_res;
    end

    // Output register; a reply stays until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks on table bookkeeping.
    `CHTAB_ASSERT_ALWAYS(a_pend_bound, r_pend_count <= PW'(MAX_PENDING),
        "pending count beyond table depth")
    `CHTAB_ASSERT_ALWAYS(a_cli_bound, r_cli_count <= CW'(MAX_CLIENTS),
        "client count beyond slot limit")
    `CHTAB_ASSERT_NEXT(a_tick_remove, r_state == ST_TICK_MOVE,
        r_pend_count == PW'($past(r_pend_count) - 1'b1),
        "removal did not shrink the pending table")
    `CHTAB_ASSERT_NEXT(a_issue_add, (r_state == ST_MOD_WAIT) && mod_done,
        (r_pend_count == PW'($past(r_pend_count) + 1'b1)) && (r_state == ST_EMIT),
        "issued challenge not stored or not replied")

endmodule

`default_nettype wire

// ===== hw/rtl/chtab_pend_mem.sv =====
// ----------------------------------------------------------------------------
// Pending challenge memory
// One write port and one registered read port holding pending entries.
// ----------------------------------------------------------------------------
`default_nettype none

module chtab_pend_mem
    import chtab_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output t_pend_entry                        o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire t_pend_entry                   i_wr_data
);

    t_pend_entry r_mem [DEPTH];
    t_pend_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data appears the cycle after the request.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/chtab_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Challenge remainder unit
// Remainder of a 32-bit word by one million through a reciprocal multiply,
// registered through capture, quotient and remainder stages.
// ----------------------------------------------------------------------------
`default_nettype none

module chtab_mod_unit
    import chtab_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    output logic             o_done,
    output logic [19:0]      o_rem
);

    logic        r_mul_vld;
    logic        r_sub_vld;
    logic        r_done;
    logic [31:0] r_value;
    logic [13:0] r_quot;
    logic [19:0] r_rem;
    logic [63:0] w_prod;
    logic [31:0] w_rem_full;

    // The scaled reciprocal gives the quotient in the product's top bits.
    assign w_prod     = {32'd0, r_value} * {32'd0, CHAL_RECIP};
    // What is left after taking out the quotient's multiple of one million.
    assign w_rem_full = r_value - (32'(r_quot) * 32'(CHAL_MOD));

    // Stage control; done stays high until the next start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
            r_sub_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_mul_vld <= i_start;
            r_sub_vld <= r_mul_vld;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_sub_vld) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: capture, quotient, remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_value <= i_value;
        end
        if (r_mul_vld) begin
            r_quot <= w_prod[63:CHAL_SHIFT];
        end
        if (r_sub_vld) begin
            r_rem <= w_rem_full[19:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
